FILE: design/hid_keyboard_to_key_matrix_macros.svh
// ---------------------------------------------------------------------------
// hid_keyboard_to_key_matrix_macros.svh
// Assertion helpers for the keyboard matrix top-level design file.
// ---------------------------------------------------------------------------
`ifndef HID_KEYBOARD_TO_KEY_MATRIX_MACROS_SVH
`define HID_KEYBOARD_TO_KEY_MATRIX_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define HKM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define HKM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/hkm_pkg.sv
// ---------------------------------------------------------------------------
// hkm_pkg
// Beat types, constants and the usage-code lookup table for the boot
// keyboard report to key matrix converter.
// ---------------------------------------------------------------------------
package hkm_pkg;

	localparam int HKM_ROWS      = 8;
	localparam int HKM_COLS      = 5;
	localparam int HKM_SLOTS_MAX = 6;

	localparam logic [7:0]          HKM_BREAK_CODE = 8'h48;
	localparam logic [7:0]          HKM_EMPTY_CODE = 8'h00;
	localparam logic [HKM_COLS-1:0] HKM_ROW_IDLE   = 5'h1f;

	// modifier byte bits
	localparam int HKM_MOD_LCTRL  = 0;
	localparam int HKM_MOD_LSHIFT = 1;
	localparam int HKM_MOD_RCTRL  = 4;
	localparam int HKM_MOD_RSHIFT = 5;

	// matrix positions of the shift and symbol keys
	localparam int HKM_SHIFT_ROW = 0;
	localparam int HKM_SHIFT_COL = 0;
	localparam int HKM_SYM_ROW   = 7;
	localparam int HKM_SYM_COL   = 1;

	typedef struct packed {
		logic [7:0] modifier_bits;
		logic [7:0] key_code_0;
		logic [7:0] key_code_1;
		logic [7:0] key_code_2;
		logic [7:0] key_code_3;
		logic [7:0] key_code_4;
		logic [7:0] key_code_5;
	} hkm_report_t;

	typedef struct packed {
		logic [4:0] row_0_bits;
		logic [4:0] row_1_bits;
		logic [4:0] row_2_bits;
		logic [4:0] row_3_bits;
		logic [4:0] row_4_bits;
		logic [4:0] row_5_bits;
		logic [4:0] row_6_bits;
		logic [4:0] row_7_bits;
		logic       break_pressed;
	} hkm_matrix_t;

	// one table entry: implied shift, implied symbol, row, column mask
	typedef struct packed {
		logic                shift;
		logic                sym;
		logic [2:0]          row;
		logic [HKM_COLS-1:0] col;
	} hkm_entry_t;

	// raw entry: bit15 shift, bit14 symbol, bits10..8 row, bits4..0 columns.
	// codes missing here (including everything from 0x58 up) map to zero.
	function automatic logic [15:0] hkm_raw_entry(input logic [7:0] code);
		logic [15:0] e;
		case (code)
			8'h04: e = 16'h0101;
			8'h05: e = 16'h0710;
			8'h06: e = 16'h0008;
			8'h07: e = 16'h0104;
			8'h08: e = 16'h0204;
			8'h09: e = 16'h0108;
			8'h0a: e = 16'h0110;
			8'h0b: e = 16'h0610;
			8'h0c: e = 16'h0504;
			8'h0d: e = 16'h0608;
			8'h0e: e = 16'h0604;
			8'h0f: e = 16'h0602;
			8'h10: e = 16'h0704;
			8'h11: e = 16'h0708;
			8'h12: e = 16'h0502;
			8'h13: e = 16'h0501;
			8'h14: e = 16'h0201;
			8'h15: e = 16'h0208;
			8'h16: e = 16'h0102;
			8'h17: e = 16'h0210;
			8'h18: e = 16'h0508;
			8'h19: e = 16'h0010;
			8'h1a: e = 16'h0202;
			8'h1b: e = 16'h0004;
			8'h1c: e = 16'h0510;
			8'h1d: e = 16'h0002;
			8'h1e: e = 16'h0301;
			8'h1f: e = 16'h0302;
			8'h20: e = 16'h0304;
			8'h21: e = 16'h0308;
			8'h22: e = 16'h0310;
			8'h23: e = 16'h0410;
			8'h24: e = 16'h0408;
			8'h25: e = 16'h0404;
			8'h26: e = 16'h0402;
			8'h27: e = 16'h0401;
			8'h28: e = 16'h0601;
			8'h2a: e = 16'h8401;
			8'h2c: e = 16'h0701;
			8'h33: e = 16'h4502;
			8'h34: e = 16'h4501;
			8'h36: e = 16'h4708;
			8'h37: e = 16'h4704;
			8'h39: e = 16'h8302;
			8'h3a: e = 16'h8301;
			8'h4f: e = 16'h8404;
			8'h50: e = 16'h8310;
			8'h51: e = 16'h8410;
			8'h52: e = 16'h8408;
			default: e = 16'h0000;
		endcase
		return e;
	endfunction

	function automatic hkm_entry_t hkm_lookup(input logic [7:0] code);
		logic [15:0] raw;
		hkm_entry_t  ent;
		raw       = hkm_raw_entry(code);
		ent.shift = raw[15];
		ent.sym   = raw[14];
		ent.row   = raw[10:8];
		ent.col   = raw[HKM_COLS-1:0];
		return ent;
	endfunction

endpackage

FILE: design/hkm_decode.sv
// ---------------------------------------------------------------------------
// hkm_decode
// Combinational conversion of one registered report into matrix rows
// and the break flag.
// ---------------------------------------------------------------------------
module hkm_decode
	import hkm_pkg::*;
#(
	parameter int KEY_SLOTS = 6
) (
	input  hkm_report_t report,
	output hkm_matrix_t matrix
);

	logic [HKM_SLOTS_MAX-1:0][7:0]          codes;
	hkm_entry_t [HKM_SLOTS_MAX-1:0]         ents;
	logic [HKM_SLOTS_MAX-1:0]               live;
	logic [HKM_SLOTS_MAX-1:0]               brk_hit;
	logic [HKM_ROWS-1:0][HKM_COLS-1:0]      clr;
	logic [HKM_ROWS-1:0][HKM_COLS-1:0]      rows;
	logic                                   shift;
	logic                                   sym;

	assign codes[0] = report.key_code_0;
	assign codes[1] = report.key_code_1;
	assign codes[2] = report.key_code_2;
	assign codes[3] = report.key_code_3;
	assign codes[4] = report.key_code_4;
	assign codes[5] = report.key_code_5;

	// per-slot lookup; slots past KEY_SLOTS are masked off
	for (genvar g = 0; g < HKM_SLOTS_MAX; g++) begin : g_slot
		assign ents[g]    = hkm_lookup(codes[g]);
		assign brk_hit[g] = (g < KEY_SLOTS) && (codes[g] == HKM_BREAK_CODE);
		assign live[g]    = (g < KEY_SLOTS) && (codes[g] != HKM_BREAK_CODE)
			&& (codes[g] != HKM_EMPTY_CODE);
	end

	always_comb begin
		clr   = '0;
		shift = report.modifier_bits[HKM_MOD_LSHIFT] | report.modifier_bits[HKM_MOD_RSHIFT];
		sym   = report.modifier_bits[HKM_MOD_LCTRL] | report.modifier_bits[HKM_MOD_RCTRL];
		for (int i = 0; i < HKM_SLOTS_MAX; i++) begin
			if (live[i]) begin
				clr[ents[i].row] = clr[ents[i].row] | ents[i].col;
				shift            = shift | ents[i].shift;
				sym              = sym | ents[i].sym;
			end
		end
		for (int r = 0; r < HKM_ROWS; r++) begin
			rows[r] = HKM_ROW_IDLE & ~clr[r];
		end
		if (shift) begin
			rows[HKM_SHIFT_ROW][HKM_SHIFT_COL] = 1'b0;
		end
		if (sym) begin
			rows[HKM_SYM_ROW][HKM_SYM_COL] = 1'b0;
		end
	end

	assign matrix.row_0_bits    = rows[0];
	assign matrix.row_1_bits    = rows[1];
	assign matrix.row_2_bits    = rows[2];
	assign matrix.row_3_bits    = rows[3];
	assign matrix.row_4_bits    = rows[4];
	assign matrix.row_5_bits    = rows[5];
	assign matrix.row_6_bits    = rows[6];
	assign matrix.row_7_bits    = rows[7];
	assign matrix.break_pressed = |brk_hit;

endmodule

FILE: design/hid_keyboard_to_key_matrix.sv
// ---------------------------------------------------------------------------
// hid_keyboard_to_key_matrix
// Boot keyboard report in, 8x5 active-low key matrix rows and break flag out.
// ---------------------------------------------------------------------------
//  channel   direction  handshake                    payload
//  report    in         report_valid / report_ready  hkm_report_t
//  matrix    out        matrix_valid / matrix_ready  hkm_matrix_t
//
//  Two register stages: report register, table lookup, result register.
//  A beat passes the report register, then the result register; one beat per cycle when not stalled.
//  Either stage refills in the cycle it empties, so back-to-back beats flow.
//  A stall on matrix_ready holds stage 2 and a full stage 1; report_ready drops only when
//  both are full and matrix_ready is low. arst_n clears the stage valid flags only.
// ---------------------------------------------------------------------------
`include "hid_keyboard_to_key_matrix_macros.svh"

module hid_keyboard_to_key_matrix
	import hkm_pkg::*;
#(
	parameter int KEY_SLOTS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        report_valid,
	output logic        report_ready,
	input  hkm_report_t report,
	output logic        matrix_valid,
	input  logic        matrix_ready,
	output hkm_matrix_t matrix
);

	logic        valid_s1;
	hkm_report_t report_s1;
	logic        valid_s2;
	hkm_matrix_t matrix_s2;
	hkm_matrix_t matrix_d;
	logic        adv_s2;
	logic        adv_s1;
	logic        load_s1;

	hkm_decode #(
		.KEY_SLOTS(KEY_SLOTS)
	) u_decode (
		.report(report_s1),
		.matrix(matrix_d)
	);

	assign adv_s2       = !valid_s2 || matrix_ready;
	assign adv_s1       = valid_s1 && adv_s2;
	assign report_ready = !valid_s1 || adv_s2;
	assign load_s1      = report_valid && report_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (report_ready) begin
				valid_s1 <= report_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			report_s1 <= report;
		end
		if (adv_s1) begin
			matrix_s2 <= matrix_d;
		end
	end

	assign matrix_valid = valid_s2;
	assign matrix       = matrix_s2;

	`HKM_ASSERT_NXT(a_load_s1, load_s1, valid_s1, "accepted beat did not reach stage 1")
	`HKM_ASSERT_NXT(a_load_s2, adv_s1, valid_s2, "stage 1 beat did not reach stage 2")
	`HKM_ASSERT_NXT(a_hold_s1, valid_s1 && !adv_s2, valid_s1 && $stable(report_s1),
		"stage 1 lost or changed its beat while stalled")
	`HKM_ASSERT_NXT(a_shift_key, adv_s1 && report_s1.modifier_bits[HKM_MOD_LSHIFT],
		!matrix.row_0_bits[HKM_SHIFT_COL], "left shift did not pull the shift column low")
	`HKM_ASSERT_IMP(a_ready, !valid_s1, report_ready, "empty stage 1 refused a beat")

endmodule
